// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/tclb_pkg.sv
// types and constants for the tty canonical line buffer
package tclb_pkg;

  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [1:0] {
    ACT_RECV = 2'd0,
    ACT_READ = 2'd1,
    ACT_DISP = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_DATA = 2'd1,
    KIND_DISP = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_FULL  = 2'd1,
    CAUSE_ERASE = 2'd2,
    CAUSE_EMPTY = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    CSEL_ZERO,
    CSEL_IN,
    CSEL_BS,
    CSEL_SP,
    CSEL_LF,
    CSEL_CR,
    CSEL_RAM
  } char_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ECHO_SP,
    S_ECHO_BS,
    S_ECHO_CR,
    S_DISP_CR,
    S_RD_DATA
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      emit;
    char_sel_t char_sel;
    kind_t     kind;
    cause_t    cause;
    logic      last;
    logic      store;
    logic      commit;
    logic      erase;
    logic      rd_start;
    logic      rd_step;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    is_bs;
    logic    is_term;
    logic    is_nl;
    logic    full;
    logic    line_empty;
    logic    rd_empty;
    logic    rd_last;
    logic    out_free;
  } status_t;

endpackage

// File: design/tty_canonical_line_buffer.sv
// Canonical-mode tty line buffer: typed bytes are edited into a ring of BUF_DEPTH
// bytes and handed out one committed line at a time. One request is taken at a
// time. A receive, display or unknown request is decoded into its first result,
// followed by any further echo bytes; a read first starts the registered read of
// the line store, then gives one byte per cycle while the output is free. Every
// result passes through a single output register, so a stalled output holds the
// request back. The line store is not cleared at reset.
module tty_canonical_line_buffer #(
  parameter int BUF_DEPTH = 128,
  parameter int MAX_READ  = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] char_in,
  input  logic [6:0] max_len,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic [1:0] out_kind,
  output logic [1:0] no_data_cause,
  output logic       last
);

  import tclb_pkg::*;

  cmd_t    cmd;
  status_t st;
  kind_t   kind_q;
  cause_t  cause_q;

  assign out_kind      = kind_q;
  assign no_data_cause = cause_q;

  tclb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tclb_dp #(
    .BUF_DEPTH (BUF_DEPTH),
    .MAX_READ  (MAX_READ)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .char_in       (char_in),
    .max_len       (max_len),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_kind      (kind_q),
    .no_data_cause (cause_q),
    .last          (last),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// File: design/tclb_ram.sv
// generic single-write, single-read ram with registered read data
module tclb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/tclb_ctrl.sv
// sequencing state machine for the line buffer
module tclb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tclb_pkg::status_t st,
  output tclb_pkg::cmd_t    cmd
);

  import tclb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.char_sel = CSEL_ZERO;
    cmd.kind     = KIND_NONE;
    cmd.cause    = CAUSE_NONE;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_next = S_IDLE;
          case (st.action)
            ACT_RECV: begin
              if (st.full) begin
                cmd.cause = CAUSE_FULL;
              end else if (st.is_bs) begin
                if (st.line_empty) begin
                  cmd.cause = CAUSE_ERASE;
                end else begin
                  cmd.erase    = 1'b1;
                  cmd.char_sel = CSEL_BS;
                  cmd.kind     = KIND_ECHO;
                  cmd.last     = 1'b0;
                  state_next   = S_ECHO_SP;
                end
              end else if (st.is_term) begin
                cmd.store    = 1'b1;
                cmd.commit   = 1'b1;
                cmd.char_sel = CSEL_LF;
                cmd.kind     = KIND_ECHO;
                cmd.last     = 1'b0;
                state_next   = S_ECHO_CR;
              end else begin
                cmd.store    = 1'b1;
                cmd.char_sel = CSEL_IN;
                cmd.kind     = KIND_ECHO;
              end
            end
            ACT_READ: begin
              if (st.rd_empty) begin
                cmd.cause = CAUSE_EMPTY;
              end else begin
                // no result yet, first byte comes out of the ram next cycle
                cmd.emit     = 1'b0;
                cmd.last     = 1'b0;
                cmd.rd_start = 1'b1;
                state_next   = S_RD_DATA;
              end
            end
            ACT_DISP: begin
              cmd.kind = KIND_DISP;
              if (st.is_nl) begin
                cmd.char_sel = CSEL_LF;
                cmd.last     = 1'b0;
                state_next   = S_DISP_CR;
              end else begin
                cmd.char_sel = CSEL_IN;
              end
            end
            default: begin
              cmd.cause = CAUSE_NONE;
            end
          endcase
        end
      end
      S_ECHO_SP: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CSEL_SP;
          cmd.kind     = KIND_ECHO;
          state_next   = S_ECHO_BS;
        end
      end
      S_ECHO_BS: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CSEL_BS;
          cmd.kind     = KIND_ECHO;
          cmd.last     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ECHO_CR: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CSEL_CR;
          cmd.kind     = KIND_ECHO;
          cmd.last     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DISP_CR: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CSEL_CR;
          cmd.kind     = KIND_DISP;
          cmd.last     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RD_DATA: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.char_sel = CSEL_RAM;
          cmd.kind     = KIND_DATA;
          cmd.last     = st.rd_last;
          cmd.rd_step  = 1'b1;
          if (st.rd_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/tclb_dp.sv
// ring pointers, line store and output register of the line buffer
module tclb_dp #(
  parameter int BUF_DEPTH = 128,
  parameter int MAX_READ  = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        action,
  input  logic [7:0]        char_in,
  input  logic [6:0]        max_len,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_char,
  output tclb_pkg::kind_t   out_kind,
  output tclb_pkg::cause_t  no_data_cause,
  output logic              last,
  input  tclb_pkg::cmd_t    cmd,
  output tclb_pkg::status_t st
);

  import tclb_pkg::*;

  localparam int PTR_W = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(MAX_READ + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(BUF_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == LAST_IDX) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == '0) ? LAST_IDX : p - 1'b1;
    return r;
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    logic r;
    r = (c == CH_LF) || (c == CH_CR) || (c == CH_EOT);
    return r;
  endfunction

  action_t          action_q;
  logic [7:0]       char_q;
  logic [CNT_W-1:0] len_q;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic [PTR_W-1:0] read_head;
  logic [PTR_W-1:0] raw_tail;
  logic [PTR_W-1:0] cooked_tail;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] raw_inc;
  logic [7:0]       ram_q;
  logic [7:0]       char_mux;

  assign head_inc = ptr_inc(read_head);
  assign raw_inc  = ptr_inc(raw_tail);
  assign cnt_inc  = cnt + 1'b1;

  tclb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (raw_tail),
    .wr_data (char_q),
    .rd_en   (cmd.rd_start | cmd.rd_step),
    .rd_addr (cmd.rd_step ? head_inc : read_head),
    .rd_data (ram_q)
  );

  // request fields, max_len clamped into 1..MAX_READ on the way in
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action_q <= action_t'(action);
      char_q   <= char_in;
      if (max_len == '0) begin
        len_q <= CNT_W'(1);
      end else if (max_len > 7'(MAX_READ)) begin
        len_q <= CNT_W'(MAX_READ);
      end else begin
        len_q <= max_len[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_head   <= '0;
      raw_tail    <= '0;
      cooked_tail <= '0;
      cnt         <= '0;
    end else begin
      if (cmd.store) begin
        raw_tail <= raw_inc;
      end else if (cmd.erase) begin
        raw_tail <= ptr_dec(raw_tail);
      end
      if (cmd.commit) begin
        cooked_tail <= raw_inc;
      end
      if (cmd.rd_start) begin
        cnt <= '0;
      end else if (cmd.rd_step) begin
        cnt       <= cnt_inc;
        read_head <= head_inc;
      end
    end
  end

  always_comb begin
    case (cmd.char_sel)
      CSEL_IN:  char_mux = char_q;
      CSEL_BS:  char_mux = CH_BS;
      CSEL_SP:  char_mux = CH_SP;
      CSEL_LF:  char_mux = CH_LF;
      CSEL_CR:  char_mux = CH_CR;
      CSEL_RAM: char_mux = ram_q;
      default:  char_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char      <= char_mux;
      out_kind      <= cmd.kind;
      no_data_cause <= cmd.cause;
      last          <= cmd.last;
    end
  end

  always_comb begin
    st.action     = action_q;
    st.is_bs      = (char_q == CH_BS) || (char_q == CH_DEL);
    st.is_term    = is_term(char_q);
    st.is_nl      = (char_q == CH_LF) || (char_q == CH_CR);
    st.full       = (raw_inc == read_head);
    st.line_empty = (raw_tail == cooked_tail);
    st.rd_empty   = (read_head == cooked_tail);
    st.rd_last    = is_term(ram_q) || (cnt_inc == len_q) || (head_inc == cooked_tail);
    st.out_free   = !out_valid || out_ready;
  end

endmodule

// File: design/tclb_checker.sv
// port-level checks for the tty canonical line buffer
`include "assert_macros.svh"

module tclb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic [1:0] out_kind,
  input logic [1:0] no_data_cause,
  input logic       last
);

  import tclb_pkg::*;

  // a result that is not taken stays put
  `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(last))

  // results that carry no byte show a zero byte
  `ASSERT_IMP(a_none_zero, out_valid && (out_kind == KIND_NONE), out_char == 8'h00)

  // a no-data cause only comes on a lone no-byte result
  `ASSERT_IMP(a_cause_none, out_valid && (no_data_cause != CAUSE_NONE), (out_kind == KIND_NONE) && last)

  // a no-byte result always closes its request
  `ASSERT_IMP(a_none_last, out_valid && (out_kind == KIND_NONE), last)

endmodule

bind tty_canonical_line_buffer tclb_checker u_tclb_checker (.*);
